/* hw/rtl/voxel_grid_point_histogram_defines.svh */
// Assertion macros shared by the voxel grid histogram RTL.
`ifndef VOXEL_GRID_POINT_HISTOGRAM_DEFINES_SVH
`define VOXEL_GRID_POINT_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset.
`define VGPH_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define VGPH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/vgph_pkg.sv */
// Shared types and constants of the voxel grid point histogram.
`timescale 1ns / 1ps
package vgph_pkg;

  localparam int COORD_W    = 32;
  localparam int COUNT_W    = 32;
  localparam int SEL_W      = 12;
  localparam int IDX_W      = 12;
  localparam int CFG_ADDR_W = 2;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 48;

  localparam logic CMD_BIN  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] REG_GRID_MIN_X      = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_MIN_Y      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_MIN_Z      = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_INV_CELL_LENGTH = 2'd3;

  localparam logic [COORD_W-1:0] INV_CELL_LENGTH_RESET = 32'h0001_0000;

  localparam int OP_QUEUE_DEPTH  = 4;
  localparam int OUT_QUEUE_DEPTH = 4;
  localparam int OP_CNT_W        = $clog2(OP_QUEUE_DEPTH + 1);
  localparam int OUT_CNT_W       = $clog2(OUT_QUEUE_DEPTH + 1);

  typedef struct packed {
    logic is_read;
    logic out_of_grid;
  } op_flags_t;

  typedef struct packed {
    logic [IDX_W-1:0]   cell_index;
    logic [COUNT_W-1:0] cell_count;
    logic               out_of_grid;
  } result_t;

endpackage

/* hw/rtl/voxel_grid_point_histogram.sv */
// Top level of the voxel grid point histogram.
`timescale 1ns / 1ps
// Bins signed Q16.16 points into a cube of 2^GRID_DEPTH cells per axis and
// keeps a saturating 32-bit count per cell; a read item returns one cell's
// count. Sustained rate is one item per clock in both directions while the
// output is not back-pressured and the queues have room. An item passes
// through the axis pipeline (subtract, then 32x32 multiply), the op queue,
// the counter read-modify-write and the output queue. The single write port
// of the counter memory takes one update per cycle by forwarding the last
// write. After reset the counters are cleared one cell per cycle, all
// 2^(3*GRID_DEPTH) cells (4096 at the default depth); s_axis_tready stays
// low meanwhile while configuration writes are still taken.
module voxel_grid_point_histogram #(
  parameter int GRID_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [vgph_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [vgph_pkg::COORD_W-1:0]        cfg_wdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pos_x [31:0], pos_y [63:32], pos_z [95:64], cell_select [107:96]
  input  logic [vgph_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // command [0]
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // cell_index [11:0], cell_count [43:12]
  output logic [vgph_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // out_of_grid [0]
  output logic                                m_axis_tuser
);
  import vgph_pkg::*;

  localparam int CellW = 3 * GRID_DEPTH;
  localparam int OpW   = $bits(op_flags_t) + CellW;
  localparam int ResW  = $bits(result_t);

  logic                 busy;
  logic                 op_push;
  op_flags_t            op_push_flags;
  logic [CellW-1:0]     op_push_cell;
  logic [OpW-1:0]       op_head;
  logic                 op_valid;
  logic [OP_CNT_W-1:0]  op_count;
  logic                 op_pop;

  logic                 res_push;
  result_t              res_data;
  logic [ResW-1:0]      res_head;
  logic [OUT_CNT_W-1:0] res_count;
  logic                 res_pop;
  result_t              res_out;

  vgph_front #(
    .GRID_DEPTH(GRID_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_axis_tvalid),
    .s_tready   (s_axis_tready),
    .s_tdata    (s_axis_tdata),
    .s_tuser    (s_axis_tuser),
    .busy       (busy),
    .q_count    (op_count),
    .push       (op_push),
    .push_flags (op_push_flags),
    .push_cell  (op_push_cell)
  );

  vgph_fifo #(
    .WIDTH(OpW),
    .DEPTH(OP_QUEUE_DEPTH)
  ) u_op_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (op_push),
    .push_data ({op_push_flags, op_push_cell}),
    .pop       (op_pop),
    .pop_data  (op_head),
    .not_empty (op_valid),
    .count     (op_count)
  );

  vgph_back #(
    .GRID_DEPTH(GRID_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .busy      (busy),
    .q_valid   (op_valid),
    .q_flags   (op_flags_t'(op_head[OpW-1:CellW])),
    .q_cell    (op_head[CellW-1:0]),
    .q_pop     (op_pop),
    .out_count (res_count),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  vgph_fifo #(
    .WIDTH(ResW),
    .DEPTH(OUT_QUEUE_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .pop       (res_pop),
    .pop_data  (res_head),
    .not_empty (m_axis_tvalid),
    .count     (res_count)
  );

  assign res_out      = result_t'(res_head);
  assign res_pop      = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata = {(OUT_DATA_W - IDX_W - COUNT_W)'(0), res_out.cell_count,
                         res_out.cell_index};
  assign m_axis_tuser = res_out.out_of_grid;

endmodule

/* hw/rtl/vgph_fifo.sv */
// Small register queue with occupancy count.
`timescale 1ns / 1ps
`include "voxel_grid_point_histogram_defines.svh"
module vgph_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty,
  output logic [CntW-1:0]  count
);

  localparam int PtrW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PtrW'(1);
      if (pop) rd_ptr <= rd_ptr + PtrW'(1);
      count <= count + CntW'(push) - CntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  assign pop_data  = slots[rd_ptr];
  assign not_empty = (count != '0);

  `VGPH_ASSERT_IMPL(a_no_overflow, push, count != CntW'(DEPTH), "queue push while full")
  `VGPH_ASSERT_IMPL(a_no_underflow, pop, count != '0, "queue pop while empty")

endmodule

/* hw/rtl/vgph_front.sv */
// Front end: configuration registers, axis index pipeline and item classification.
`timescale 1ns / 1ps
module vgph_front #(
  parameter int GRID_DEPTH = 4,
  localparam int CellW = 3 * GRID_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [vgph_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [vgph_pkg::COORD_W-1:0]         cfg_wdata,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [vgph_pkg::IN_DATA_W-1:0]       s_tdata,
  input  logic                                 s_tuser,
  input  logic                                 busy,
  input  logic [vgph_pkg::OP_CNT_W-1:0]        q_count,
  output logic                                 push,
  output vgph_pkg::op_flags_t                  push_flags,
  output logic [CellW-1:0]                     push_cell
);
  import vgph_pkg::*;

  localparam logic [COORD_W-1:0] Steps = 32'd1 << GRID_DEPTH;

  logic [COORD_W-1:0] grid_min [3];
  logic [COORD_W-1:0] inv_len;

  logic               accept;
  logic [OP_CNT_W-1:0] outstanding;
  logic [COORD_W:0]   diff [3];

  logic               v1;
  logic               cmd1;
  logic [SEL_W-1:0]   sel1;
  logic               neg1 [3];
  logic [COORD_W-1:0] dmag1 [3];

  logic               v2;
  logic               cmd2;
  logic [SEL_W-1:0]   sel2;
  logic               neg2 [3];
  logic [COORD_W-1:0] k2 [3];

  logic [2*COORD_W-1:0]  prod [3];
  logic                  axis_oob [3];
  logic [GRID_DEPTH-1:0] axis_idx [3];
  logic                  is_read;
  logic                  oob;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_min[0] <= '0;
      grid_min[1] <= '0;
      grid_min[2] <= '0;
      inv_len     <= INV_CELL_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GRID_MIN_X:      grid_min[0] <= cfg_wdata;
        REG_GRID_MIN_Y:      grid_min[1] <= cfg_wdata;
        REG_GRID_MIN_Z:      grid_min[2] <= cfg_wdata;
        REG_INV_CELL_LENGTH: inv_len     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Credit check: everything in flight here must fit in the op queue.
  assign outstanding = q_count + OP_CNT_W'(v1) + OP_CNT_W'(v2);
  assign s_tready    = !rst && !busy && (outstanding < OP_CNT_W'(OP_QUEUE_DEPTH));
  assign accept      = s_tvalid && s_tready;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a] = {s_tdata[a*COORD_W + COORD_W-1], s_tdata[a*COORD_W +: COORD_W]}
              - {grid_min[a][COORD_W-1], grid_min[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    cmd1 <= s_tuser;
    sel1 <= s_tdata[3*COORD_W +: SEL_W];
    cmd2 <= cmd1;
    sel2 <= sel1;
    for (int a = 0; a < 3; a++) begin
      neg1[a]  <= diff[a][COORD_W];
      dmag1[a] <= diff[a][COORD_W-1:0];
      neg2[a]  <= neg1[a];
      k2[a]    <= prod[a][2*COORD_W-1:COORD_W];
    end
  end

  // Exact Q16.16 x Q16.16 product; the integer part is the axis index.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod[a] = (2*COORD_W)'(dmag1[a]) * (2*COORD_W)'(inv_len);
    end
  end

  // A zero reciprocal already gives k = 0, so negative differences only
  // leave the grid when the reciprocal is nonzero.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      axis_oob[a] = (neg2[a] && (inv_len != '0)) || (k2[a] > Steps);
      axis_idx[a] = (k2[a] == Steps) ? {GRID_DEPTH{1'b1}} : k2[a][GRID_DEPTH-1:0];
    end
    is_read = (cmd2 == CMD_READ);
    oob     = !is_read && (axis_oob[0] || axis_oob[1] || axis_oob[2]);
  end

  assign push                   = v2;
  assign push_flags.is_read     = is_read;
  assign push_flags.out_of_grid = oob;
  assign push_cell = is_read ? CellW'(sel2)
                   : (oob ? '0 : {axis_idx[0], axis_idx[1], axis_idx[2]});

endmodule

/* hw/rtl/vgph_back.sv */
// Back end: counter memory with clearing pass, read-modify-write and forwarding.
`timescale 1ns / 1ps
`include "voxel_grid_point_histogram_defines.svh"
module vgph_back #(
  parameter int GRID_DEPTH = 4,
  localparam int CellW = 3 * GRID_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  output logic                           busy,
  input  logic                           q_valid,
  input  vgph_pkg::op_flags_t            q_flags,
  input  logic [CellW-1:0]               q_cell,
  output logic                           q_pop,
  input  logic [vgph_pkg::OUT_CNT_W-1:0] out_count,
  output logic                           res_push,
  output vgph_pkg::result_t              res_data
);
  import vgph_pkg::*;

  localparam int NumCells = 1 << CellW;

  logic [COUNT_W-1:0] counts [NumCells];
  logic [COUNT_W-1:0] rd_data;

  logic               clearing;
  logic [CellW-1:0]   clr_addr;

  logic               b1_valid;
  op_flags_t          b1_flags;
  logic [CellW-1:0]   b1_cell;

  logic               wr_seen;
  logic [CellW-1:0]   last_wr_addr;
  logic [COUNT_W-1:0] last_wr_data;

  logic               wr_en;
  logic [CellW-1:0]   wr_addr;
  logic [COUNT_W-1:0] wr_data;
  logic [COUNT_W-1:0] cur;
  logic [COUNT_W-1:0] bumped;

  assign busy  = clearing;
  assign q_pop = q_valid && !clearing
              && ((out_count + OUT_CNT_W'(b1_valid)) < OUT_CNT_W'(OUT_QUEUE_DEPTH));

  // Sweep every counter to zero after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + CellW'(1);
      if (&clr_addr) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else begin
      b1_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_flags <= q_flags;
      b1_cell  <= q_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) counts[wr_addr] <= wr_data;
    rd_data <= counts[q_cell];
  end

  // The read in the same edge as the previous write sees the old value: take
  // the latest write instead when it hit the same cell.
  assign cur    = (wr_seen && (last_wr_addr == b1_cell)) ? last_wr_data : rd_data;
  assign bumped = (&cur) ? cur : cur + COUNT_W'(1);

  assign wr_en   = clearing || (b1_valid && !b1_flags.is_read && !b1_flags.out_of_grid);
  assign wr_addr = clearing ? clr_addr : b1_cell;
  assign wr_data = clearing ? '0 : bumped;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_seen <= 1'b0;
    end else if (wr_en) begin
      wr_seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_wr_addr <= wr_addr;
      last_wr_data <= wr_data;
    end
  end

  assign res_push             = b1_valid;
  assign res_data.cell_index  = IDX_W'(b1_cell);
  assign res_data.out_of_grid = b1_flags.out_of_grid;
  assign res_data.cell_count  = b1_flags.out_of_grid ? '0
                              : (b1_flags.is_read ? cur : bumped);

  `VGPH_ASSERT_IMPL(a_idle_while_clearing, clearing, !b1_valid && !q_pop,
    "counter access during clearing pass")
  `VGPH_ASSERT_IMPL(a_bin_count_nonzero,
    b1_valid && !b1_flags.is_read && !b1_flags.out_of_grid, res_data.cell_count != '0,
    "binned cell reports zero count")
  `VGPH_ASSERT_IMPL(a_oob_zero_index, b1_valid && b1_flags.out_of_grid,
    res_data.cell_index == '0, "out-of-grid item carries a cell index")

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the voxel grid point histogram.
`timescale 1ns / 1ps
module tb_top;
  import vgph_pkg::*;

  localparam int GRID_DEPTH  = 4;
  localparam int STEPS       = 1 << GRID_DEPTH;
  localparam int NUM_CELLS   = 1 << (3 * GRID_DEPTH);
  localparam int PHASE_ITEMS = 215;
  localparam int NUM_PHASES  = 6;
  localparam int STALL_LIMIT = 20000;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  typedef struct {
    logic             command;
    logic [31:0]      pos_x;
    logic [31:0]      pos_y;
    logic [31:0]      pos_z;
    logic [SEL_W-1:0] cell_select;
  } point_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [COORD_W-1:0]    cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  // Configuration as the block holds it.
  logic [31:0] cur_min_x = '0;
  logic [31:0] cur_min_y = '0;
  logic [31:0] cur_min_z = '0;
  logic [31:0] cur_inv_len = INV_CELL_LENGTH_RESET;

  logic [COUNT_W-1:0] cell_tally [NUM_CELLS];
  point_item_t        point_queue [$];
  result_t            cell_reports [$];
  point_item_t        drive_item;
  point_item_t        last_bin;
  logic [SEL_W-1:0]   last_cell = '0;
  logic               s_fire = 1'b0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 error_count = 0;
  int                 quiet_cycles = 0;

  always #5 clk = ~clk;

  voxel_grid_point_histogram #(
    .GRID_DEPTH(GRID_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  // Axis index of one coordinate; returns 0 when it falls off the grid.
  function automatic bit axis_cell(input logic [31:0] pos, input logic [31:0] minv,
                                   output int unsigned k);
    logic signed [32:0] diff;
    logic [63:0]        prod;
    diff = $signed({pos[31], pos}) - $signed({minv[31], minv});
    if (diff < 0) begin
      if (cur_inv_len != 0) return 0;
      k = 0;
    end else begin
      prod = 64'(diff[31:0]) * 64'(cur_inv_len);
      if (prod[63:32] > STEPS) return 0;
      k = prod[63:32];
    end
    if (k == STEPS) k = STEPS - 1;
    return 1;
  endfunction

  function automatic bit locate_cell(input point_item_t it, output logic [SEL_W-1:0] cell_id);
    int unsigned ix, iy, iz;
    if (!axis_cell(it.pos_x, cur_min_x, ix) || !axis_cell(it.pos_y, cur_min_y, iy) ||
        !axis_cell(it.pos_z, cur_min_z, iz)) return 0;
    cell_id = SEL_W'((ix * STEPS * STEPS + iy * STEPS + iz) & (NUM_CELLS - 1));
    return 1;
  endfunction

  // Update the cell counts for one item and queue the report it should give.
  task automatic tally_point(input point_item_t it);
    result_t          r;
    logic [SEL_W-1:0] cell_id;
    r = '0;
    if (it.command == CMD_READ) begin
      cell_id = SEL_W'(it.cell_select & (NUM_CELLS - 1));
      r.cell_index = cell_id;
      r.cell_count = cell_tally[cell_id];
    end else if (locate_cell(it, cell_id)) begin
      if (cell_tally[cell_id] != '1) cell_tally[cell_id] = cell_tally[cell_id] + 1;
      r.cell_index = cell_id;
      r.cell_count = cell_tally[cell_id];
    end else begin
      r.out_of_grid = 1'b1;
    end
    cell_reports.insert(cell_reports.size(), r);
  endtask

  function automatic logic [31:0] gen_coord(input logic [31:0] minv, input bit well_formed);
    logic [63:0] span;
    logic [63:0] edge16;
    logic [63:0] offset;
    int unsigned pick;
    pick = $urandom_range(99);
    offset = {$urandom, $urandom};
    if (cur_inv_len == 0) begin
      // every axis index is 0; mix points above and below the minimum
      if (pick < 50) return minv - (offset[31:0] >> $urandom_range(31));
      return well_formed ? minv + offset[31:0] : $urandom;
    end
    span = (64'(STEPS + 1) << 32) / cur_inv_len;
    edge16 = ((64'(STEPS) << 32) + cur_inv_len - 1) / cur_inv_len;
    if (well_formed) begin
      if (pick < 80) offset = offset % span;
      else if (pick < 90) offset = edge16;
      else offset = edge16 - 1;
    end else begin
      if (pick < 40) return minv - 32'd1 - (offset[31:0] >> $urandom_range(31));
      else if (pick < 70) offset = span + offset % span;
      else return $urandom;
    end
    return minv + offset[31:0];
  endfunction

  function automatic point_item_t make_point();
    point_item_t      it;
    int unsigned      pick;
    bit               wf;
    logic [SEL_W-1:0] cell_id;
    pick = $urandom_range(99);
    it.command = CMD_BIN;
    it.pos_x = $urandom;
    it.pos_y = $urandom;
    it.pos_z = $urandom;
    it.cell_select = $urandom;
    if (pick < 15) begin
      it.command = CMD_READ;
      if ($urandom_range(1)) it.cell_select = last_cell;
    end else if (pick < 27) begin
      // hit the same counter again, often back to back
      it = last_bin;
    end else begin
      wf = ($urandom_range(99) < 75);
      it.pos_x = gen_coord(cur_min_x, wf);
      it.pos_y = gen_coord(cur_min_y, wf);
      it.pos_z = gen_coord(cur_min_z, wf);
    end
    if (it.command == CMD_BIN && locate_cell(it, cell_id)) begin
      last_bin = it;
      last_cell = cell_id;
    end
    return it;
  endfunction

  task automatic push_point(input logic cmd, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [SEL_W-1:0] sel);
    point_item_t it;
    it.command = cmd;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.cell_select = sel;
    point_queue.insert(point_queue.size(), it);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    case (addr)
      REG_GRID_MIN_X:      cur_min_x = data;
      REG_GRID_MIN_Y:      cur_min_y = data;
      REG_GRID_MIN_Z:      cur_min_z = data;
      REG_INV_CELL_LENGTH: cur_inv_len = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_grid(input int phase);
    logic [31:0] mx, my, mz, inv;
    case (phase)
      0: begin
        mx = '0; my = '0; mz = '0; inv = ONE_Q16;
      end
      1: begin
        // half-unit cells, minimums near both ends of the range
        mx = 32'hFFF8_0000; my = 32'h8000_0000; mz = 32'h7FFF_0000; inv = 32'h0002_0000;
      end
      2: begin
        mx = $urandom; my = $urandom; mz = $urandom; inv = '0;
      end
      3: begin
        mx = 32'h7FFF_FFFF; my = 32'h8000_0000; mz = '0; inv = 32'hFFFF_FFFF;
      end
      4: begin
        // one grid spanning the whole coordinate range
        mx = 32'h8000_0000; my = 32'h8000_0000; mz = 32'h8000_0000; inv = 32'd16;
      end
      default: begin
        mx = $urandom; my = $urandom; mz = $urandom; inv = $urandom_range(1, 32'h0020_0000);
      end
    endcase
    write_reg(REG_GRID_MIN_X, mx);
    write_reg(REG_GRID_MIN_Y, my);
    write_reg(REG_GRID_MIN_Z, mz);
    write_reg(REG_INV_CELL_LENGTH, inv);
  endtask

  task automatic push_directed();
    push_point(CMD_BIN, '0, '0, '0, '0);
    push_point(CMD_BIN, 32'h000F_FFFF, 32'h000F_FFFF, 32'h000F_FFFF, 12'hFFF);
    // exactly on the far edge: clamped into the last cell
    push_point(CMD_BIN, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000, '0);
    repeat (4) push_point(CMD_BIN, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, '0);
    push_point(CMD_READ, '0, '0, '0, 12'h123);
    push_point(CMD_BIN, 32'h0010_0000, '0, 32'h0011_0000, '0);
    push_point(CMD_BIN, 32'h0011_0000, '0, '0, '0);
    push_point(CMD_BIN, '0, 32'hFFFF_FFFF, '0, '0);
    push_point(CMD_BIN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 12'hFFF);
    push_point(CMD_BIN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0);
    push_point(CMD_READ, '0, '0, '0, '0);
    push_point(CMD_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    push_point(CMD_READ, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 12'h001);
  endtask

  task automatic wait_drained();
    while (point_queue.size() != 0 || s_axis_tvalid || cell_reports.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < NUM_CELLS; i++) cell_tally[i] = '0;
    last_bin = '{CMD_BIN, '0, '0, '0, '0};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase < 2) begin
        send_idle_pct = 37;
        recv_idle_pct = 83;
      end else if (phase < 4) begin
        send_idle_pct = 83;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_grid(phase);
      @(posedge clk);
      if (phase == 0) push_directed();
      for (int n = 0; n < PHASE_ITEMS; n++) point_queue.insert(point_queue.size(), make_point());
      wait_drained();
    end
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Record accepted items and watch for a stalled block.
  always @(posedge clk) begin
    if (rst) begin
      s_fire <= 1'b0;
    end else begin
      s_fire <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) tally_point(drive_item);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("tb_top NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      // hold the item until it is taken
      if (!s_axis_tvalid || s_fire) begin
        if (point_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_item = point_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {4'b0, drive_item.cell_select, drive_item.pos_z,
                           drive_item.pos_y, drive_item.pos_x};
          s_axis_tuser <= drive_item.command;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (cell_reports.size() == 0) begin
        $display("%0t: unexpected item: cell_index %h cell_count %h out_of_grid %b",
                 $realtime, m_axis_tdata[11:0], m_axis_tdata[43:12], m_axis_tuser);
        error_count++;
      end else begin
        want = cell_reports.pop_front();
        if (m_axis_tdata[11:0] !== want.cell_index) begin
          $display("%0t: cell_index expected %h actual %h",
                   $realtime, want.cell_index, m_axis_tdata[11:0]);
          error_count++;
        end
        if (m_axis_tdata[43:12] !== want.cell_count) begin
          $display("%0t: cell_count expected %h actual %h",
                   $realtime, want.cell_count, m_axis_tdata[43:12]);
          error_count++;
        end
        if (m_axis_tuser !== want.out_of_grid) begin
          $display("%0t: out_of_grid expected %b actual %b",
                   $realtime, want.out_of_grid, m_axis_tuser);
          error_count++;
        end
      end
    end
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/vgph_pkg.sv
hw/rtl/vgph_fifo.sv
hw/rtl/vgph_front.sv
hw/rtl/vgph_back.sv
hw/rtl/voxel_grid_point_histogram.sv
tb/sv/tb_top.sv
